[design/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/wsfr_pkg.sv]
// Types and constants of the WebSocket frame receiver.
package wsfr_pkg;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Payload kinds on the result port
  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd1;
  localparam logic [1:0] KIND_PING   = 2'd2;
  localparam logic [1:0] KIND_PONG   = 2'd3;

  // Length codes and header lengths
  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;
  localparam logic [3:0] HLEN_SHORT   = 4'd6;
  localparam logic [3:0] HLEN_16      = 4'd8;
  localparam logic [3:0] HLEN_64      = 4'd14;
  localparam logic [3:0] MASK_BYTES   = 4'd4;

  // Header byte masks
  localparam logic [7:0] RSV_MASK    = 8'h70;
  localparam logic [7:0] OPCODE_MASK = 8'h0F;
  localparam logic [7:0] LEN_MASK    = 8'h7F;
  localparam logic [7:0] TOP_BIT     = 8'h80;

  // Close codes
  localparam logic [15:0] CLOSE_NO_STATUS = 16'd1005;
  localparam logic [15:0] CLOSE_PROTOCOL  = 16'd1002;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [1:0]  kind;
    logic        last;
    logic        close_seen;
    logic        error;
    logic [15:0] close_code;
  } wsfr_result_t;

endpackage

[design/websocket_frame_receiver_unit.sv]
// WebSocket frame receiver: header parse, checks, unmasking, output buffer.
// Each result is registered in the output register, or in the skid entry
// while the output is held. Throughput: one byte per cycle; a two-entry output buffer
// (register plus skid) keeps in_ready registered and stalls only when full.
// Reset (rst, synchronous, active high) returns the parser to the first header
// byte, clears all frame state and reopens the connection.
`include "assert_macros.svh"

module websocket_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        data_valid,
  output logic [1:0]  kind,
  output logic        last,
  output logic        close_seen,
  output logic        error,
  output logic [15:0] close_code
);
  import wsfr_pkg::*;

  // ---------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------
  logic [3:0]  header_index,      header_index_next;
  logic        frame_fin,         frame_fin_next;
  logic [3:0]  frame_opcode,      frame_opcode_next;
  logic [6:0]  length_code,       length_code_next;
  logic [63:0] payload_remaining, payload_remaining_next;
  logic [31:0] mask_key,          mask_key_next;
  logic [1:0]  mask_phase,        mask_phase_next;
  logic        in_fragment,       in_fragment_next;
  logic        message_binary,    message_binary_next;
  logic [15:0] close_reason_acc,  close_reason_acc_next;
  logic        closed,            closed_next;

  // Output register and skid entry
  wsfr_result_t out_data, skid_data;
  logic         skid_valid;

  // Per-byte working values
  logic         accept, pop, push;
  wsfr_result_t res;
  logic         is_control;
  logic [31:0]  key_word;
  logic [7:0]   unmasked;
  logic [15:0]  acc_new;
  logic [3:0]   hlen, idx_inc;
  logic [63:0]  rem_new;
  logic         binary_new;
  logic         rem_one;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  // Ready only depends on the skid entry, so it is a registered decision.
  assign in_ready = !skid_valid;

  assign is_control = frame_opcode[3];
  assign key_word   = mask_key << {mask_phase, 3'b000};
  assign unmasked   = rx_byte ^ key_word[31:24];
  assign rem_one    = (payload_remaining == 64'd1);
  assign idx_inc    = header_index + 4'd1;

  always_comb begin
    case (length_code)
      LEN_CODE_16: hlen = HLEN_16;
      LEN_CODE_64: hlen = HLEN_64;
      default:     hlen = HLEN_SHORT;
    endcase
  end

  // ---------------------------------------------------------------------
  // Next-state and result logic for one accepted byte
  // ---------------------------------------------------------------------
  always_comb begin
    header_index_next      = header_index;
    frame_fin_next         = frame_fin;
    frame_opcode_next      = frame_opcode;
    length_code_next       = length_code;
    payload_remaining_next = payload_remaining;
    mask_key_next          = mask_key;
    mask_phase_next        = mask_phase;
    in_fragment_next       = in_fragment;
    message_binary_next    = message_binary;
    close_reason_acc_next  = close_reason_acc;
    closed_next            = closed;
    res                    = '0;
    push                   = 1'b0;
    acc_new                = close_reason_acc;
    rem_new                = payload_remaining;
    binary_new             = message_binary;

    if (accept && !closed) begin
      if (header_index == 4'd0 && payload_remaining != 64'd0) begin
        // Payload byte: unmask with the rotating key.
        mask_phase_next        = mask_phase + 2'd1;
        payload_remaining_next = payload_remaining - 64'd1;
        if (frame_opcode == OP_CLOSE) begin
          // Close frames stay below 126 bytes, so the low bits give the offset.
          if (payload_remaining[6:0] == length_code) begin
            acc_new[15:8] = unmasked;
          end else if ({1'b0, payload_remaining[6:0]} + 8'd1 == {1'b0, length_code}) begin
            acc_new[7:0] = unmasked;
          end
          close_reason_acc_next = acc_new;
          if (rem_one) begin
            closed_next     = 1'b1;
            push            = 1'b1;
            res.close_seen  = 1'b1;
            res.close_code  = (length_code >= 7'd2) ? acc_new : CLOSE_NO_STATUS;
          end
        end else begin
          push           = 1'b1;
          res.data_byte  = unmasked;
          res.data_valid = 1'b1;
          res.kind       = (frame_opcode == OP_PING) ? KIND_PING :
                           (frame_opcode == OP_PONG) ? KIND_PONG :
                           (message_binary ? KIND_BINARY : KIND_TEXT);
          res.last       = rem_one && (is_control || frame_fin);
        end
      end else if (header_index == 4'd0) begin
        // First header byte: FIN, reserved bits, opcode.
        if ((rx_byte & RSV_MASK) != 8'h00) begin
          closed_next    = 1'b1;
          push           = 1'b1;
          res.error      = 1'b1;
          res.close_code = CLOSE_PROTOCOL;
        end else begin
          frame_fin_next    = rx_byte[7];
          frame_opcode_next = rx_byte[3:0];
          header_index_next = 4'd1;
        end
      end else if (header_index == 4'd1) begin
        // Second header byte: mask bit, length code, frame-order checks.
        if (((rx_byte & TOP_BIT) == 8'h00)
            || (is_control && ((rx_byte[6:0] > LEN_CTRL_MAX) || !frame_fin))
            || (frame_opcode inside {[4'd3:4'd7], [4'd11:4'd15]})
            || (!in_fragment && frame_opcode == OP_CONT)
            || (in_fragment && frame_opcode != OP_CONT && !is_control)) begin
          closed_next    = 1'b1;
          push           = 1'b1;
          res.error      = 1'b1;
          res.close_code = CLOSE_PROTOCOL;
        end else begin
          length_code_next       = rx_byte[6:0];
          payload_remaining_next = (rx_byte[6:0] < LEN_CODE_16) ?
                                   {57'd0, rx_byte[6:0]} : 64'd0;
          mask_key_next          = 32'd0;
          close_reason_acc_next  = 16'd0;
          header_index_next      = 4'd2;
        end
      end else begin
        // Extended length bytes, then the four mask key bytes.
        if (header_index < hlen - MASK_BYTES) begin
          rem_new                = {payload_remaining[55:0], rx_byte};
          payload_remaining_next = rem_new;
        end else begin
          mask_key_next = {mask_key[23:0], rx_byte};
        end
        header_index_next = idx_inc;
        if (idx_inc == hlen) begin
          header_index_next = 4'd0;
          mask_phase_next   = 2'd0;
          if (length_code == LEN_CODE_64 && rem_new[63]) begin
            closed_next    = 1'b1;
            push           = 1'b1;
            res.error      = 1'b1;
            res.close_code = CLOSE_PROTOCOL;
          end else begin
            if (!is_control) begin
              if (frame_opcode != OP_CONT) begin
                binary_new = (frame_opcode == OP_BINARY);
              end
              message_binary_next = binary_new;
              in_fragment_next    = !frame_fin;
            end
            if (rem_new == 64'd0) begin
              if (frame_opcode == OP_CLOSE) begin
                closed_next    = 1'b1;
                push           = 1'b1;
                res.close_seen = 1'b1;
                res.close_code = (length_code >= 7'd2) ? close_reason_acc : CLOSE_NO_STATUS;
              end else if (is_control || frame_fin) begin
                // Empty frame still marks the end of its message.
                push     = 1'b1;
                res.last = 1'b1;
                res.kind = (frame_opcode == OP_PING) ? KIND_PING :
                           (frame_opcode == OP_PONG) ? KIND_PONG :
                           (binary_new ? KIND_BINARY : KIND_TEXT);
              end
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      header_index      <= '0;
      frame_fin         <= 1'b0;
      frame_opcode      <= OP_CONT;
      length_code       <= '0;
      payload_remaining <= '0;
      mask_key          <= '0;
      mask_phase        <= '0;
      in_fragment       <= 1'b0;
      message_binary    <= 1'b0;
      close_reason_acc  <= '0;
      closed            <= 1'b0;
    end else begin
      header_index      <= header_index_next;
      frame_fin         <= frame_fin_next;
      frame_opcode      <= frame_opcode_next;
      length_code       <= length_code_next;
      payload_remaining <= payload_remaining_next;
      mask_key          <= mask_key_next;
      mask_phase        <= mask_phase_next;
      in_fragment       <= in_fragment_next;
      message_binary    <= message_binary_next;
      close_reason_acc  <= close_reason_acc_next;
      closed            <= closed_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid entry. A new result goes to the output
  // register when it is free or being drained, otherwise to the skid.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  assign data_byte  = out_data.data_byte;
  assign data_valid = out_data.data_valid;
  assign kind       = out_data.kind;
  assign last       = out_data.last;
  assign close_seen = out_data.close_seen;
  assign error      = out_data.error;
  assign close_code = out_data.close_code;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The skid entry only fills behind a held output transaction.
  `ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // Once closed, the connection stays closed until reset.
  `ASSERT_NEXT(a_closed_sticks, clk, rst, closed, closed)
  // A close or error result always closes the connection.
  `ASSERT_NEXT(a_final_closes, clk, rst, push && (res.error || res.close_seen), closed)
  // A closed block produces no further results.
  `ASSERT_IMPL(a_no_result_closed, clk, rst, closed, !push)

endmodule
